>>> rtl/core/ffba_pkg.sv
// package for the first-fit block allocator
// holds the field widths, request and status codes and the sequencer states
// no dependencies
`default_nettype none

package ffba_pkg;

    // fixed field widths
    localparam int SIZE_W   = 14;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 4;

    // packed stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_REUSED        = 4'd0,
        STAT_APPENDED      = 4'd1,
        STAT_MARKED_FREE   = 4'd2,
        STAT_TAIL_RELEASED = 4'd3,
        STAT_ZERO_SIZE     = 4'd4,
        STAT_HEAP_FULL     = 4'd5,
        STAT_TABLE_FULL    = 4'd6,
        STAT_NULL          = 4'd7,
        STAT_INVALID       = 4'd8
    } t_status;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESOLVE,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/ffba_table.sv
// block table memory of the first-fit block allocator
// one write port and one registered read port; no dependencies
`default_nettype none

module ffba_table #(
    parameter int DEPTH = 32,
    parameter int EW    = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_idx,
    input  wire logic [EW-1:0]            i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_idx,
    output logic      [EW-1:0]            o_rd_data
);

    logic [EW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_idx];
    end

endmodule

`default_nettype wire

>>> rtl/core/first_fit_block_allocator.sv
// first-fit block allocator: a zero-size or null item goes straight to the result stage
// once taken; any other item walks the table, one entry per cycle through the table read
// port and the shared compare unit, up to the first match or the last entry, and then
// resolves its result. the next item is taken in the cycle after the result moves to the
// output register; a finished item waits only while an earlier result is still held for
// o_m_axis_tvalid/i_m_axis_tready. i_rst_n is synchronous, active low, and empties the
// table and the heap; table contents stay undefined until written.
// depends on ffba_pkg and ffba_table
`default_nettype none

module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int HEAP_WORDS   = 1024,
    parameter int MAX_BLOCKS   = 32,
    parameter int HEADER_WORDS = 4,
    parameter int WORD_BYTES   = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input item
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [S_DATA_W-1:0] i_s_axis_tdata,  // size_bytes[13:0], data_address[23:14]
    input  wire logic                i_s_axis_tuser,  // req_type
    // result item
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic      [M_DATA_W-1:0] o_m_axis_tdata,  // result_address[9:0], zero pad
    output logic      [STATUS_W-1:0] o_m_axis_tuser   // status[3:0]
);

    // widths derived from the parameters
    localparam int AW  = $clog2(HEAP_WORDS);          // block start
    localparam int TW  = AW + 1;                      // heap top
    localparam int IW  = $clog2(MAX_BLOCKS);          // table index
    localparam int CW  = $clog2(MAX_BLOCKS + 1);      // block count
    localparam int EW  = AW + SIZE_W + 1;             // table entry
    localparam int XW  = (AW + 1 > ADDR_W) ? AW + 1 : ADDR_W;
    localparam int WW  = 16;                          // block length in words
    localparam int SW  = ((TW > WW) ? TW : WW) + 1;   // top plus length
    // ceil division by WORD_BYTES as a reciprocal multiply, exact for 15-bit operands
    localparam int RK  = 18;
    localparam int RM  = ((1 << RK) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RMW = RK + 1;
    localparam int PW  = SIZE_W + 1 + RMW;

    // data word address of a block start
    function automatic logic [ADDR_W-1:0] data_addr(input logic [AW-1:0] start);
        logic [XW-1:0] sum;
        sum = XW'(start) + XW'(HEADER_WORDS);
        return sum[ADDR_W-1:0];
    endfunction

    t_state             r_state, n_state;
    logic               r_req;
    logic [SIZE_W-1:0]  r_size;
    logic [ADDR_W-1:0]  r_addr;
    logic [WW-1:0]      r_words;
    logic [CW-1:0]      r_count, n_count;
    logic [TW-1:0]      r_top, n_top;
    logic [CW-1:0]      r_idx;
    logic               r_chk_vld;
    logic [IW-1:0]      r_chk_idx;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [EW-1:0]      r_hit_entry;
    t_status            r_status, n_status;
    logic [ADDR_W-1:0]  r_res_addr, n_res_addr;
    logic               r_out_vld;
    t_status            r_out_status;
    logic [ADDR_W-1:0]  r_out_addr;

    logic               s_accept;
    logic               m_done;
    logic               out_free;
    logic               issue;
    logic               hit;
    logic [EW-1:0]      rd_data;
    logic               wr_en;
    logic [IW-1:0]      wr_idx;
    logic [EW-1:0]      wr_data;

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign m_done   = o_m_axis_tvalid && i_m_axis_tready;
    assign out_free = !r_out_vld || i_m_axis_tready;
    assign issue    = (r_idx < r_count);

    // block table
    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .EW    (EW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (r_idx[IW-1:0]),
        .o_rd_data (rd_data)
    );

    // entry fields of the word being checked and of the hit
    logic [AW-1:0]     rd_start;
    logic [SIZE_W-1:0] rd_size;
    logic              rd_free;
    logic [AW-1:0]     hit_start;
    assign rd_start  = rd_data[AW-1:0];
    assign rd_size   = rd_data[AW+SIZE_W-1:AW];
    assign rd_free   = rd_data[EW-1];
    assign hit_start = r_hit_entry[AW-1:0];

    // shared compare unit: size fit on allocate, address match on free
    logic [SIZE_W-1:0] cmp_a, cmp_b;
    logic [SIZE_W:0]   cmp_diff;
    logic              cmp_ge, cmp_eq;
    always_comb begin
        if (r_req == REQ_ALLOC) begin
            cmp_a = rd_size;
            cmp_b = r_size;
        end else begin
            cmp_a = SIZE_W'(data_addr(rd_start));
            cmp_b = SIZE_W'(r_addr);
        end
        cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
        cmp_ge   = !cmp_diff[SIZE_W];
        cmp_eq   = (cmp_diff == '0);
    end
    assign hit = r_chk_vld && ((r_req == REQ_ALLOC) ? (rd_free && cmp_ge) : cmp_eq);

    // block length in words: header plus rounded-up size
    logic [SIZE_W:0] round_up;
    logic [PW-1:0]   recip_prod;
    assign round_up   = {1'b0, r_size} + (SIZE_W + 1)'(WORD_BYTES - 1);
    assign recip_prod = PW'(round_up) * PW'(RM);

    always_ff @(posedge i_clk) begin
        r_words <= WW'(HEADER_WORDS) + recip_prod[RK+WW-1:RK];
    end

    // append fit test
    logic [SW-1:0] top_sum;
    logic          heap_fits;
    assign top_sum   = SW'(r_top) + SW'(r_words);
    assign heap_fits = (top_sum < SW'(HEAP_WORDS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if ((i_s_axis_tuser == REQ_ALLOC && i_s_axis_tdata[SIZE_W-1:0] == '0)
                        || (i_s_axis_tuser == REQ_FREE
                            && i_s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W] == '0)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (hit || (!r_chk_vld && !issue)) begin
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and table updates
    always_comb begin
        n_status   = r_status;
        n_res_addr = r_res_addr;
        n_count    = r_count;
        n_top      = r_top;
        wr_en      = 1'b0;
        wr_idx     = r_hit_idx;
        wr_data    = {1'b0, r_hit_entry[EW-2:0]};
        case (r_state)
            S_IDLE: begin
                n_res_addr = '0;
                n_status   = (i_s_axis_tuser == REQ_ALLOC) ? STAT_ZERO_SIZE : STAT_NULL;
            end
            S_RESOLVE: begin
                if (r_req == REQ_ALLOC) begin
                    if (r_hit) begin
                        // reuse the first fitting free block
                        wr_en      = 1'b1;
                        n_status   = STAT_REUSED;
                        n_res_addr = data_addr(hit_start);
                    end else if (!heap_fits) begin
                        n_status = STAT_HEAP_FULL;
                    end else if (r_count == CW'(MAX_BLOCKS)) begin
                        n_status = STAT_TABLE_FULL;
                    end else begin
                        // append at the heap top
                        wr_en      = 1'b1;
                        wr_idx     = r_count[IW-1:0];
                        wr_data    = {1'b0, r_size, r_top[AW-1:0]};
                        n_status   = STAT_APPENDED;
                        n_res_addr = data_addr(r_top[AW-1:0]);
                        n_count    = r_count + 1'b1;
                        n_top      = top_sum[TW-1:0];
                    end
                end else begin
                    if (!r_hit) begin
                        n_status = STAT_INVALID;
                    end else if (CW'(r_hit_idx) + 1'b1 == r_count) begin
                        // last block goes back to the heap top
                        n_status = STAT_TAIL_RELEASED;
                        n_count  = r_count - 1'b1;
                        n_top    = TW'(hit_start);
                    end else begin
                        wr_en    = 1'b1;
                        wr_data  = {1'b1, r_hit_entry[EW-2:0]};
                        n_status = STAT_MARKED_FREE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_top     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            if (r_state == S_SCAN) begin
                r_chk_vld <= issue && !hit;
            end else begin
                r_chk_vld <= 1'b0;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_done) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request, scan and result registers
    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_res_addr <= n_res_addr;
        r_chk_idx  <= r_idx[IW-1:0];
        if (s_accept) begin
            r_req  <= i_s_axis_tuser;
            r_size <= i_s_axis_tdata[SIZE_W-1:0];
            r_addr <= i_s_axis_tdata[SIZE_W+ADDR_W-1:SIZE_W];
            r_idx  <= '0;
            r_hit  <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_chk_idx;
                r_hit_entry <= rd_data;
            end
        end
    end

    // output register, loaded once the previous result is gone
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && out_free) begin
            r_out_status <= r_status;
            r_out_addr   <= r_res_addr;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = M_DATA_W'(r_out_addr);
    assign o_m_axis_tuser  = r_out_status;

`ifndef ASSERT_OFF
    // a waiting result holds still
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result changed while waiting");

    // table count and heap top stay in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BLOCKS))
        else $error("block count out of range");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top < TW'(HEAP_WORDS))
        else $error("heap top out of range");

    // empty table means empty heap
    a_empty_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == '0))
        else $error("heap top nonzero with empty table");

    // only successful allocations carry an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid
         && !(o_m_axis_tuser == STAT_REUSED || o_m_axis_tuser == STAT_APPENDED))
        |-> (o_m_axis_tdata == '0))
        else $error("address on failed or free result");
`endif

endmodule

`default_nettype wire
